// ===== src/thf_pkg.sv =====
package thf_pkg;

	typedef struct packed {
		logic signed [15:0] sample;
		logic [15:0]        channel_id;
		logic               last_sample;
	} in_t;

	typedef struct packed {
		logic [15:0]        hit_channel;
		logic [15:0]        start_time;
		logic signed [31:0] hit_charge;
		logic [15:0]        time_over_threshold;
	} out_t;

	// finished hit waiting for the charge division
	typedef struct packed {
		logic [15:0]        chan;
		logic [15:0]        start;
		logic signed [31:0] charge;
		logic [15:0]        dur;
	} hit_req_t;

	typedef struct packed {
		logic [14:0] threshold;
		logic [4:0]  factor;
		logic [15:0] gain;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_FACTOR    = 2'd1;
	localparam logic [1:0] REG_GAIN      = 2'd2;

	localparam logic [14:0] THRESHOLD_RST = 15'd10;
	localparam logic [4:0]  FACTOR_RST    = 5'd1;
	localparam logic [15:0] GAIN_RST      = 16'd99;

endpackage

// ===== src/threshold_hit_finder.sv =====
// Channel  Handshake                 Payload  Direction
// req      req_valid / req_ready     in_t     sample in
// hit      hit_valid / hit_ready     out_t    hit out
// apb      psel/penable/pwrite/pready cfg regs at 0x0, 0x4, 0x8
//
// Samples are taken one per cycle while the two-entry hit queue has room.
// Each finished hit passes through the serial divider (load, 32 quotient
// steps, output) and then waits in the output for hit_ready; the divider
// sets the sustained hit rate.
// Reset clears the hit state, sample index and queue; registers return to
// threshold 10, factor 1, gain 99.
module threshold_hit_finder import thf_pkg::*; #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  in_t         req,
	output logic        hit_valid,
	input  logic        hit_ready,
	output out_t        hit,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg_q;
	logic     push;
	logic     pop;
	hit_req_t push_data;
	hit_req_t q_data;
	q_stat_t  q_stat;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RST;
			cfg_q.factor    <= FACTOR_RST;
			cfg_q.gain      <= GAIN_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_THRESHOLD: cfg_q.threshold <= pwdata[14:0];
				REG_FACTOR:    cfg_q.factor    <= pwdata[4:0];
				REG_GAIN:      cfg_q.gain      <= pwdata[15:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_THRESHOLD: prdata = 32'(cfg_q.threshold);
			REG_FACTOR:    prdata = 32'(cfg_q.factor);
			REG_GAIN:      prdata = 32'(cfg_q.gain);
			default:       prdata = '0;
		endcase
	end

	thf_front #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	thf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (q_data),
		.stat    (q_stat)
	);

	thf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (cfg_q.gain),
		.q_stat    (q_stat),
		.q_data    (q_data),
		.pop       (pop),
		.hit_valid (hit_valid),
		.hit_ready (hit_ready),
		.hit       (hit)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full) else $error("hit queue overrun");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty) else $error("hit queue underrun");

	a_last_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.last_sample) |-> !push)
		else $error("hit emitted on last sample");

	a_pop_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !hit_valid) else $error("divider took a hit while output busy");
`endif

endmodule

// ===== src/thf_front.sv =====
module thf_front import thf_pkg::*; #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     req_valid,
	output logic     req_ready,
	input  in_t      req,
	input  q_stat_t  q_stat,
	output logic     push,
	output hit_req_t push_data
);

	localparam int IW = $clog2(MAX_SAMPLES);
	localparam logic [IW-1:0] IDX_LAST = IW'(MAX_SAMPLES - 1);

	logic               in_hit_q;
	logic [IW-1:0]      idx_q;
	logic [15:0]        start_q;
	logic signed [31:0] charge_q;
	logic [15:0]        dur_q;

	logic               accept;
	logic               over;
	logic signed [21:0] wprod;
	logic signed [33:0] csum;
	logic signed [31:0] csat;
	logic [16:0]        dsum;
	logic [15:0]        dsat;
	logic [IW+4:0]      sprod;

	assign req_ready = !q_stat.full;
	assign accept    = req_valid && req_ready;
	assign over      = req.sample > $signed({1'b0, cfg.threshold});

	assign wprod = req.sample * $signed({1'b0, cfg.factor});
	assign csum  = {{2{charge_q[31]}}, charge_q} + {{12{wprod[21]}}, wprod};
	always_comb begin
		if (csum[33:31] == 3'b000 || csum[33:31] == 3'b111) begin
			csat = csum[31:0];
		end else if (csum[33]) begin
			csat = 32'sh8000_0000;
		end else begin
			csat = 32'sh7fff_ffff;
		end
	end

	assign dsum = {1'b0, dur_q} + 17'(cfg.factor);
	assign dsat = dsum[16] ? 16'hffff : dsum[15:0];

	assign sprod = idx_q * cfg.factor;

	assign push = accept && !req.last_sample && !over && in_hit_q;
	always_comb begin
		push_data.chan   = req.channel_id;
		push_data.start  = start_q;
		push_data.charge = charge_q;
		push_data.dur    = dur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_hit_q <= 1'b0;
			idx_q    <= '0;
			start_q  <= '0;
			charge_q <= '0;
			dur_q    <= '0;
		end else if (accept) begin
			if (req.last_sample) begin
				in_hit_q <= 1'b0;
				idx_q    <= '0;
				start_q  <= '0;
				charge_q <= '0;
				dur_q    <= '0;
			end else begin
				if (over && !in_hit_q) begin
					start_q  <= 16'(sprod);
					charge_q <= 32'(req.sample);
					dur_q    <= 16'(cfg.factor);
				end else if (over) begin
					charge_q <= csat;
					dur_q    <= dsat;
				end
				in_hit_q <= over;
				idx_q    <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== src/thf_fifo.sv =====
module thf_fifo import thf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  hit_req_t wr_data,
	input  logic     pop,
	output hit_req_t rd_data,
	output q_stat_t  stat
);

	hit_req_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign rd_data    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/thf_div.sv =====
module thf_div import thf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] gain,
	input  q_stat_t     q_stat,
	input  hit_req_t    q_data,
	output logic        pop,
	output logic        hit_valid,
	input  logic        hit_ready,
	output out_t        hit
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

	state_t      state_q;
	logic [31:0] dvd_q;
	logic [15:0] rem_q;
	logic [15:0] dsr_q;
	logic [4:0]  cnt_q;
	logic        neg_q;
	logic [15:0] chan_q;
	logic [15:0] start_q;
	logic [15:0] dur_q;
	out_t        hit_q;

	logic [16:0] trial;
	logic        qbit;
	logic [31:0] quo;

	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign hit_valid = (state_q == ST_OUT);
	assign hit       = hit_q;

	// restoring division on the magnitude, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[31]};
	assign qbit  = (trial >= {1'b0, dsr_q});
	assign quo   = {dvd_q[30:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dvd_q   <= '0;
			rem_q   <= '0;
			dsr_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			chan_q  <= '0;
			start_q <= '0;
			dur_q   <= '0;
			hit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						neg_q   <= q_data.charge[31];
						dvd_q   <= q_data.charge[31] ? 32'(-q_data.charge) : q_data.charge;
						rem_q   <= '0;
						dsr_q   <= (gain == 16'd0) ? 16'd1 : gain;
						cnt_q   <= '0;
						chan_q  <= q_data.chan;
						start_q <= q_data.start;
						dur_q   <= q_data.dur;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= qbit ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
					dvd_q <= quo;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						hit_q.hit_channel         <= chan_q;
						hit_q.start_time          <= start_q;
						hit_q.hit_charge          <= neg_q ? -$signed(quo) : $signed(quo);
						hit_q.time_over_threshold <= dur_q;
						state_q                   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (hit_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	import thf_pkg::*;

	localparam int MAX_SAMPLES   = 4096;
	localparam int HIT_LATENCY   = 40;   // divider load + 32 steps + output, with margin
	localparam int RANDOM_ITEMS  = 1950;
	localparam int RANDOM_PHASES = 6;
	localparam int CYCLE_LIMIT   = 2_000_000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	in_t         req       = '0;
	logic        hit_valid;
	logic        hit_ready = 1'b0;
	out_t        hit;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	threshold_hit_finder #(.MAX_SAMPLES(MAX_SAMPLES)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.hit_valid (hit_valid),
		.hit_ready (hit_ready),
		.hit       (hit),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	// hit finder mirror: registers and running hit state
	int     threshold_q = THRESHOLD_RST;
	int     factor_q    = FACTOR_RST;
	int     gain_q      = GAIN_RST;
	bit     in_hit_q    = 1'b0;
	int     sample_idx_q = 0;
	int     start_q     = 0;
	longint charge_q    = 0;
	int     tot_q       = 0;

	out_t expected_hits[$];
	int   errors    = 0;
	int   cycles    = 0;
	bit   idle_on   = 1'b0;
	int   stall_cnt = 0;

	function automatic void predict_hit(in_t it);
		int     adc;
		int     divisor;
		longint acc;
		bit     over;
		out_t   res;
		adc = it.sample;
		if (it.last_sample) begin
			in_hit_q     = 1'b0;
			sample_idx_q = 0;
			start_q      = 0;
			charge_q     = 0;
			tot_q        = 0;
			return;
		end
		over = adc > threshold_q;
		if (over && !in_hit_q) begin
			start_q  = (sample_idx_q * factor_q) & 'hFFFF;
			charge_q = adc;
			tot_q    = factor_q;
		end else if (over && in_hit_q) begin
			acc = charge_q + longint'(adc) * factor_q;
			if (acc > 64'sd2147483647)
				acc = 64'sd2147483647;
			else if (acc < -64'sd2147483648)
				acc = -64'sd2147483648;
			charge_q = acc;
			tot_q += factor_q;
			if (tot_q > 'hFFFF)
				tot_q = 'hFFFF;
		end else if (!over && in_hit_q) begin
			divisor = (gain_q == 0) ? 1 : gain_q;
			res.hit_channel         = it.channel_id;
			res.start_time          = start_q[15:0];
			res.hit_charge          = 32'(charge_q / longint'(divisor));
			res.time_over_threshold = tot_q[15:0];
			expected_hits.insert(expected_hits.size(), res);
		end
		in_hit_q = over;
		sample_idx_q++;
		if (sample_idx_q >= MAX_SAMPLES)
			sample_idx_q = 0;
	endfunction

	function automatic int below_level();
		if ($urandom_range(0, 1))
			return $urandom_range(0, threshold_q);
		return int'($urandom_range(0, threshold_q + 32768)) - 32768;
	endfunction

	function automatic int above_level();
		if (threshold_q >= 32767)
			return below_level();
		return $urandom_range(threshold_q + 1, 32767);
	endfunction

	task automatic send_sample(input int value, input logic [15:0] chan, input bit last);
		in_t it;
		it.sample      = value[15:0];
		it.channel_id  = chan;
		it.last_sample = last;
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_hit(it);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic drain_hits();
		req_valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		// a hit may still be in the divider with nothing queued behind it
		repeat (HIT_LATENCY) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_THRESHOLD: threshold_q = value & 'h7FFF;
			REG_FACTOR:    factor_q    = value & 'h1F;
			REG_GAIN:      gain_q      = value & 'hFFFF;
			default: ;
		endcase
		// leave the bus idle before the next transfer
		@(posedge clk);
	endtask

	task automatic configure(input int thr, input int fac, input int gain);
		drain_hits();
		apb_write(REG_THRESHOLD, thr);
		apb_write(REG_FACTOR, fac);
		apb_write(REG_GAIN, gain);
	endtask

	task automatic test_default_config();
		send_sample(5, 16'd0, 1'b0);
		send_sample(11, 16'd0, 1'b0);
		send_sample(32767, 16'd0, 1'b0);
		send_sample(10, 16'hFFFF, 1'b0);    // at threshold closes the hit
		send_sample(20, 16'd1, 1'b0);
		send_sample(30, 16'd1, 1'b0);
		send_sample(32767, 16'd1, 1'b1);    // open hit dropped, index back to zero
		send_sample(15, 16'd2, 1'b0);
		send_sample(-32768, 16'd2, 1'b0);
	endtask

	task automatic test_register_extremes();
		// zero factor and zero gain
		configure(10, 0, 0);
		send_sample(100, 16'd3, 1'b0);
		send_sample(200, 16'd3, 1'b0);
		send_sample(-1, 16'd3, 1'b0);
		send_sample(0, 16'd3, 1'b1);
		configure(32767, 31, 65535);
		send_sample(32767, 16'd4, 1'b0);
		send_sample(-32768, 16'd4, 1'b0);
		send_sample(0, 16'd4, 1'b1);
		configure(0, 16, 1);
		send_sample(0, 16'd5, 1'b0);
		send_sample(1, 16'd5, 1'b0);
		send_sample(32767, 16'd5, 1'b0);
		send_sample(0, 16'd5, 1'b0);
		send_sample(0, 16'd5, 1'b1);
	endtask

	// long pulse saturates charge and duration, then pulses past the index wrap
	task automatic test_long_waveform();
		logic [15:0] chan;
		int n;
		int run;
		configure(0, 31, $urandom_range(1, 65535));
		chan = 16'($urandom);
		send_sample(below_level(), chan, 1'b1);
		for (n = 0; n < 2300; n++)
			send_sample($urandom_range(32000, 32767), chan, 1'b0);
		send_sample(below_level(), chan, 1'b0);
		n = 2301;
		while (n < 4400) begin
			run = $urandom_range(20, 200);
			repeat (run) send_sample(below_level(), chan, 1'b0);
			n += run;
			run = $urandom_range(1, 8);
			repeat (run) send_sample(above_level(), chan, 1'b0);
			n += run;
		end
		send_sample(below_level(), chan, 1'b0);
		send_sample($urandom, chan, 1'b1);
	endtask

	task automatic test_random_waveforms();
		int          per_phase;
		int          p;
		int          sent;
		int          len;
		int          value;
		bit          pulse;
		logic [15:0] chan;
		per_phase = RANDOM_ITEMS / RANDOM_PHASES;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: configure(0, 1, 1);
				1: configure(32766, 16, 65535);
				2: configure($urandom_range(0, 500), 31, 0);
				default: configure($urandom_range(0, 3000), $urandom_range(0, 31),
					$urandom_range(0, 1) ? $urandom_range(1, 400) : $urandom_range(0, 65535));
			endcase
			idle_on = (p % 3 != 2);
			sent = 0;
			while (sent < per_phase) begin
				chan  = 16'($urandom);
				len   = $urandom_range(1, 60);
				pulse = 1'b0;
				repeat (len) begin
					if ($urandom_range(0, 3) == 0)
						pulse = !pulse;
					if ($urandom_range(0, 11) == 0)
						value = $urandom;
					else
						value = pulse ? above_level() : below_level();
					if ($urandom_range(0, 15) == 0)
						chan = 16'($urandom);
					send_sample(value, chan, 1'b0);
				end
				sent += len;
				// some waveforms run into the next one without an end marker
				if ($urandom_range(0, 7) != 0)
					send_sample($urandom, 16'($urandom), 1'b1);
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_cnt > 0)
			stall_cnt--;
		else if (idle_on && $urandom_range(0, 11) == 0)
			stall_cnt = $urandom_range(1, 17);
		hit_ready <= (stall_cnt == 0);
	end

	always @(posedge clk) begin
		out_t want;
		bit   bad;
		if (arst_n && hit_valid && hit_ready) begin
			if (expected_hits.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected hit: ch %0d start %0d charge %0d tot %0d",
						hit.hit_channel, hit.start_time, hit.hit_charge,
						hit.time_over_threshold);
			end else begin
				want = expected_hits.pop_front();
				bad = hit.hit_channel !== want.hit_channel ||
					hit.start_time !== want.start_time ||
					hit.hit_charge !== want.hit_charge ||
					hit.time_over_threshold !== want.time_over_threshold;
				if (bad) begin
					errors++;
					if (errors <= 10)
						$display("hit mismatch: exp ch %0d start %0d charge %0d tot %0d, got ch %0d start %0d charge %0d tot %0d",
							want.hit_channel, want.start_time, want.hit_charge,
							want.time_over_threshold, hit.hit_channel, hit.start_time,
							hit.hit_charge, hit.time_over_threshold);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d hits outstanding", expected_hits.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_default_config();
		test_register_extremes();
		test_long_waveform();
		test_random_waveforms();
		drain_hits();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
